// ===== rtl/rdbim_pkg.sv =====
// ----------------------------------------------------------------------------
// rdbim_pkg: shared types, constants and functions of the input monitor
// Fixed-point widths, status codes, register indexes, the decoded tick beat,
// the message beat and the filter update arithmetic.
// ----------------------------------------------------------------------------
package rdbim_pkg;

  // Fixed-point format of the filter levels: one integer bit.
  localparam int FRACTION_BITS = 16;
  localparam int LEVEL_W       = FRACTION_BITS + 1;
  localparam int DIFF_W        = FRACTION_BITS + 2;
  localparam int PROD_W        = 2 * FRACTION_BITS + 3;
  localparam int SUM_W         = FRACTION_BITS + 3;

  // Configuration registers are Q0.16 / Q1.16 values, 17 bits wide.
  localparam int REG_W       = 17;
  localparam int REG_FRAC    = 16;
  localparam int WIDE_W      = REG_W + FRACTION_BITS;
  localparam int CFG_INDEX_W = 2;

  localparam int NUM_FILTERS = 7;
  localparam int QUEUE_DEPTH = 2;
  localparam int MSG_SLOTS   = 3;

  localparam logic [LEVEL_W-1:0] ONE_LEVEL  = {1'b1, {FRACTION_BITS{1'b0}}};
  localparam logic [LEVEL_W-1:0] HALF_LEVEL = {2'b01, {(FRACTION_BITS - 1){1'b0}}};

  localparam logic [REG_W-1:0] GAIN_RESET = 17'd655;
  localparam logic [REG_W-1:0] HIGH_RESET = 17'd58982;
  localparam logic [REG_W-1:0] LOW_RESET  = 17'd6554;

  // Register indexes.
  localparam logic [CFG_INDEX_W-1:0] REG_GAIN = 2'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_HIGH = 2'd1;
  localparam logic [CFG_INDEX_W-1:0] REG_LOW  = 2'd2;

  // Filter slots.
  localparam int FLT_ERROR   = 0;
  localparam int FLT_OPEN    = 1;
  localparam int FLT_CLOSED  = 2;
  localparam int FLT_UNKNOWN = 3;
  localparam int FLT_FAILED  = 4;
  localparam int FLT_DOOR    = 5;
  localparam int FLT_BUTTON  = 6;

  // Message sources.
  localparam logic [1:0] SRC_RELAY  = 2'd0;
  localparam logic [1:0] SRC_DOOR   = 2'd1;
  localparam logic [1:0] SRC_BUTTON = 2'd2;

  // Relay classes.
  localparam logic [2:0] RELAY_UNKNOWN = 3'd0;
  localparam logic [2:0] RELAY_NO_ON   = 3'd1;
  localparam logic [2:0] RELAY_NC_ON   = 3'd2;
  localparam logic [2:0] RELAY_BOTH_ON = 3'd3;
  localparam logic [2:0] RELAY_FAILED  = 3'd4;
  localparam logic [2:0] RELAY_NONE    = 3'd7;

  // Door and button classes.
  localparam logic [1:0] DOOR_AJAR    = 2'd1;
  localparam logic [1:0] DOOR_SHUT    = 2'd2;
  localparam logic [1:0] BTN_PRESSED  = 2'd1;
  localparam logic [1:0] BTN_RELEASED = 2'd2;
  localparam logic [1:0] SIDE_NONE    = 2'd3;

  // One tick after decoding: filter targets and the message budget.
  // relay_tgt bit i is the target of filter i (error, open, closed, unknown).
  typedef struct packed {
    logic [3:0] relay_tgt;
    logic       door_tgt;
    logic       button_tgt;
    logic [1:0] space;
  } tick_t;

  typedef struct packed {
    logic  valid;
    tick_t data;
  } tick_beat_t;

  typedef struct packed {
    logic [1:0] source;
    logic [2:0] status_code;
    logic       last_of_tick;
  } msg_t;

  // Rescale a 16-fraction-bit register to the level format.
  function automatic logic [LEVEL_W-1:0] scale_reg(input logic [REG_W-1:0] r);
    logic [WIDE_W-1:0] w;
    w = {{FRACTION_BITS{1'b0}}, r} << FRACTION_BITS;
    w = w >> REG_FRAC;
    return w[LEVEL_W-1:0];
  endfunction

  // Floor-shift the product, add it to the level and clamp to [0, 1.0].
  function automatic logic [LEVEL_W-1:0] level_update(input logic [LEVEL_W-1:0] level,
                                                      input logic signed [PROD_W-1:0] prod);
    logic signed [PROD_W-1:0] shifted;
    logic signed [SUM_W-1:0]  sum;
    logic [LEVEL_W-1:0]       res;
    shifted = prod >>> FRACTION_BITS;
    sum     = signed'({2'b00, level}) + signed'(shifted[SUM_W-1:0]);
    if (sum[SUM_W-1]) begin
      res = '0;
    end else if (sum > signed'({2'b00, ONE_LEVEL})) begin
      res = ONE_LEVEL;
    end else begin
      res = sum[LEVEL_W-1:0];
    end
    return res;
  endfunction

endpackage

// ===== rtl/relay_door_button_input_monitor_core.sv =====
// An accepted tick beat is registered in the input stage, waits in the queue, then runs
// the four filter passes and the report cycle; its messages leave one message beat per
// cycle while the consumer does not stall. Tick rate is set by the two shared multiplier
// lanes that step the seven filters in four passes, plus the report cycle of each tick.
// Reset (synchronous, active high): filters to 0.5, registers to their defaults,
// nothing reported yet, queue and message buffer empty.
// ----------------------------------------------------------------------------
// relay_door_button_input_monitor_core: relay, door and push-button monitor
// Smooths the pin levels of each millisecond tick with seven fixed-point
// filters and reports class changes of relay, door and button as messages.
// ----------------------------------------------------------------------------
//
// Structure:
//   rdbim_front  registers each accepted tick beat and decodes the active-low
//                pins into filter targets (error, open, closed, unknown,
//                door, button) along with the message budget of the tick.
//   rdbim_queue  a two-entry queue of decoded ticks. The input side keeps
//                taking beats while the engine is busy with an earlier tick.
//   rdbim_back   the filter engine. Two multiplier lanes run the updates
//                v += (alpha * (target - v)) >>> FRACTION_BITS with clamping.
//                Pass one steps the error and open filters, pass two the
//                closed and unknown filters, pass three door and button, and
//                pass four the failed filter, whose target needs the freshly
//                stepped relay filters. Products are registered before the
//                add and clamp. The report cycle classifies, compares against
//                the last reported classes and loads up to three messages into
//                a small output buffer that drains one beat per cycle while the consumer does not stall.
//
// The report cycle waits while messages of the previous tick are still in the
// buffer; with a consumer that never stalls the buffer is always drained by
// the time the next report comes around. Messages beyond the budget of a tick
// are not sent, and since the reported class stays unchanged they come up
// again on a later tick.
//
// Configuration writes land directly in the engine registers and are meant to
// happen only while the block is idle.
module relay_door_button_input_monitor_core (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              cfg_we,
  input  logic [rdbim_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  logic [rdbim_pkg::REG_W-1:0]       cfg_data,
  input  logic                              item_valid,
  output logic                              item_stall,
  input  logic                              relay_open_pin,
  input  logic                              relay_closed_pin,
  input  logic                              door_pin,
  input  logic                              button_pin,
  input  logic [1:0]                        queue_space,
  output logic                              msg_valid,
  input  logic                              msg_stall,
  output logic [1:0]                        source,
  output logic [2:0]                        status_code,
  output logic                              last_of_tick
);
  import rdbim_pkg::*;

  // Decoded tick handed from the input stage to the queue.
  tick_beat_t push;
  logic       full;

  // Head of the queue and the engine's take signal.
  tick_beat_t head;
  logic       pop;

  rdbim_front u_front (
    .clk              (clk),
    .rst              (rst),
    .item_valid       (item_valid),
    .item_stall       (item_stall),
    .relay_open_pin   (relay_open_pin),
    .relay_closed_pin (relay_closed_pin),
    .door_pin         (door_pin),
    .button_pin       (button_pin),
    .queue_space      (queue_space),
    .push             (push),
    .full             (full)
  );

  rdbim_queue u_queue (
    .clk  (clk),
    .rst  (rst),
    .push (push),
    .full (full),
    .head (head),
    .pop  (pop)
  );

  rdbim_back u_back (
    .clk          (clk),
    .rst          (rst),
    .cfg_we       (cfg_we),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .head         (head),
    .pop          (pop),
    .msg_valid    (msg_valid),
    .msg_stall    (msg_stall),
    .source       (source),
    .status_code  (status_code),
    .last_of_tick (last_of_tick)
  );

endmodule

// ===== rtl/rdbim_front.sv =====
// ----------------------------------------------------------------------------
// rdbim_front: input stage of the monitor
// Takes tick beats, decodes the active-low pins into filter targets and
// holds the decoded tick until the queue takes it.
// ----------------------------------------------------------------------------
module rdbim_front (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   item_valid,
  output logic                   item_stall,
  input  logic                   relay_open_pin,
  input  logic                   relay_closed_pin,
  input  logic                   door_pin,
  input  logic                   button_pin,
  input  logic [1:0]             queue_space,
  output rdbim_pkg::tick_beat_t  push,
  input  logic                   full
);
  import rdbim_pkg::*;

  logic  held_valid;
  tick_t held;
  tick_t decoded;
  logic  no_act;
  logic  nc_act;
  logic  accept;

  always_comb begin
    no_act             = ~relay_open_pin;
    nc_act             = ~relay_closed_pin;
    decoded.relay_tgt  = {~no_act & ~nc_act, ~no_act & nc_act,
                          no_act & ~nc_act, no_act & nc_act};
    decoded.door_tgt   = ~door_pin;
    decoded.button_tgt = ~button_pin;
    decoded.space      = queue_space;
  end

  assign item_stall = held_valid & full;
  assign accept     = item_valid & ~item_stall;
  assign push.valid = held_valid;
  assign push.data  = held;

  always_ff @(posedge clk) begin
    if (rst) begin
      held_valid <= 1'b0;
    end else if (accept) begin
      held_valid <= 1'b1;
    end else if (held_valid && !full) begin
      held_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      held <= decoded;
    end
  end

endmodule

// ===== rtl/rdbim_queue.sv =====
// ----------------------------------------------------------------------------
// rdbim_queue: short queue of decoded ticks
// Decouples the input stage from the filter engine so each side can stall
// on its own.
// ----------------------------------------------------------------------------
module rdbim_queue (
  input  logic                  clk,
  input  logic                  rst,
  input  rdbim_pkg::tick_beat_t push,
  output logic                  full,
  output rdbim_pkg::tick_beat_t head,
  input  logic                  pop
);
  import rdbim_pkg::*;

  localparam int AW = $clog2(QUEUE_DEPTH);
  localparam int CW = $clog2(QUEUE_DEPTH + 1);

  tick_t         entry [QUEUE_DEPTH];
  logic [AW-1:0] wr_ptr;
  logic [AW-1:0] rd_ptr;
  logic [CW-1:0] count;
  logic          wr_en;
  logic          rd_en;

  assign full       = (count == CW'(QUEUE_DEPTH));
  assign wr_en      = push.valid & ~full;
  assign rd_en      = pop & (count != '0);
  assign head.valid = (count != '0);
  assign head.data  = entry[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (wr_en) begin
        wr_ptr <= (wr_ptr == AW'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (rd_en) begin
        rd_ptr <= (rd_ptr == AW'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (wr_en && !rd_en) begin
        count <= count + 1'b1;
      end else if (rd_en && !wr_en) begin
        count <= count - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      entry[wr_ptr] <= push.data;
    end
  end

endmodule

// ===== rtl/rdbim_back.sv =====
// ----------------------------------------------------------------------------
// rdbim_back: filter engine, classifier and message buffer
// Two multiplier lanes step the seven filters over four passes, then one
// report cycle classifies and loads the messages of the tick.
// ----------------------------------------------------------------------------
module rdbim_back (
  input  logic                                   clk,
  input  logic                                   rst,
  input  logic                                   cfg_we,
  input  logic [rdbim_pkg::CFG_INDEX_W-1:0]      cfg_index,
  input  logic [rdbim_pkg::REG_W-1:0]            cfg_data,
  input  rdbim_pkg::tick_beat_t                  head,
  output logic                                   pop,
  output logic                                   msg_valid,
  input  logic                                   msg_stall,
  output logic [1:0]                             source,
  output logic [2:0]                             status_code,
  output logic                                   last_of_tick
);
  import rdbim_pkg::*;

  typedef enum logic [5:0] {
    ST_IDLE   = 6'b000001,
    ST_PAIR01 = 6'b000010,
    ST_PAIR23 = 6'b000100,
    ST_PAIR56 = 6'b001000,
    ST_FAIL   = 6'b010000,
    ST_REPORT = 6'b100000
  } state_t;

  state_t state;
  state_t state_next;

  logic [REG_W-1:0]   gain;
  logic [REG_W-1:0]   high_thr;
  logic [REG_W-1:0]   low_thr;
  logic [LEVEL_W-1:0] alpha;
  logic [LEVEL_W-1:0] hi;
  logic [LEVEL_W-1:0] lo;

  logic [LEVEL_W-1:0] level [NUM_FILTERS];
  logic [2:0]         reported_relay;
  logic [1:0]         reported_door;
  logic [1:0]         reported_button;
  tick_t              cur;

  // Multiplier lanes.
  logic [LEVEL_W-1:0]       lv_a;
  logic [LEVEL_W-1:0]       lv_b;
  logic                     tg_a;
  logic                     tg_b;
  logic [LEVEL_W-1:0]       lv_a_q;
  logic [LEVEL_W-1:0]       lv_b_q;
  logic signed [DIFF_W-1:0] alpha_s;
  logic signed [DIFF_W-1:0] diff_a;
  logic signed [DIFF_W-1:0] diff_b;
  logic signed [PROD_W-1:0] prod_a;
  logic signed [PROD_W-1:0] prod_b;
  logic [LEVEL_W-1:0]       upd_a;
  logic [LEVEL_W-1:0]       upd_b;

  // Classification.
  logic [3:0] above;
  logic [3:0] below;
  logic       fail_tgt;
  logic       relay_v;
  logic [2:0] relay_code;
  logic       door_v;
  logic [1:0] door_code;
  logic       btn_v;
  logic [1:0] btn_code;
  logic       emit_r;
  logic       emit_d;
  logic       emit_b;
  logic [1:0] space1;
  logic [1:0] space2;
  logic       report_fire;

  // Message buffer, slot 0 is the head.
  msg_t       slot [MSG_SLOTS];
  msg_t       new_slot [MSG_SLOTS];
  msg_t       m_r;
  msg_t       m_d;
  msg_t       m_b;
  logic [1:0] count;
  logic [1:0] count_new;
  logic       buf_empty;
  logic       out_pop;

  assign alpha = scale_reg(gain);
  assign hi    = scale_reg(high_thr);
  assign lo    = scale_reg(low_thr);

  assign buf_empty   = (count == 2'd0);
  assign report_fire = (state == ST_REPORT) & buf_empty;
  assign pop         = head.valid & ((state == ST_IDLE) | report_fire);

  // Lane operand selection per pass.
  always_comb begin
    lv_a = level[FLT_ERROR];
    tg_a = cur.relay_tgt[FLT_ERROR];
    lv_b = level[FLT_OPEN];
    tg_b = cur.relay_tgt[FLT_OPEN];
    case (state)
      ST_PAIR23: begin
        lv_a = level[FLT_CLOSED];
        tg_a = cur.relay_tgt[FLT_CLOSED];
        lv_b = level[FLT_UNKNOWN];
        tg_b = cur.relay_tgt[FLT_UNKNOWN];
      end
      ST_PAIR56: begin
        lv_a = level[FLT_DOOR];
        tg_a = cur.door_tgt;
        lv_b = level[FLT_BUTTON];
        tg_b = cur.button_tgt;
      end
      ST_FAIL: begin
        lv_a = level[FLT_FAILED];
        tg_a = fail_tgt;
        lv_b = level[FLT_FAILED];
        tg_b = 1'b0;
      end
      default: begin
      end
    endcase
  end

  always_comb begin
    alpha_s = signed'({1'b0, alpha});
    diff_a  = signed'({1'b0, tg_a, {FRACTION_BITS{1'b0}}}) - signed'({1'b0, lv_a});
    diff_b  = signed'({1'b0, tg_b, {FRACTION_BITS{1'b0}}}) - signed'({1'b0, lv_b});
  end

  assign upd_a = level_update(lv_a_q, prod_a);
  assign upd_b = level_update(lv_b_q, prod_b);

  // Threshold tests on the relay filters, valid once they have been stepped.
  always_comb begin
    for (int i = 0; i < 4; i++) begin
      above[i] = level[i] > hi;
      below[i] = level[i] < hi;
    end
    fail_tgt = &below;
  end

  always_comb begin
    relay_v    = 1'b1;
    relay_code = RELAY_UNKNOWN;
    if (above[0] && below[1] && below[2] && below[3]) begin
      relay_code = RELAY_BOTH_ON;
    end else if (below[0] && above[1] && below[2] && below[3]) begin
      relay_code = RELAY_NO_ON;
    end else if (below[0] && below[1] && above[2] && below[3]) begin
      relay_code = RELAY_NC_ON;
    end else if (below[0] && below[1] && below[2] && above[3]) begin
      relay_code = RELAY_UNKNOWN;
    end else if (upd_a > hi) begin
      relay_code = RELAY_FAILED;
    end else begin
      relay_v = 1'b0;
    end

    door_v    = 1'b1;
    door_code = DOOR_SHUT;
    if (level[FLT_DOOR] > hi) begin
      door_code = DOOR_SHUT;
    end else if (level[FLT_DOOR] < lo) begin
      door_code = DOOR_AJAR;
    end else begin
      door_v = 1'b0;
    end

    btn_v    = 1'b1;
    btn_code = BTN_PRESSED;
    if (level[FLT_BUTTON] > hi) begin
      btn_code = BTN_PRESSED;
    end else if (level[FLT_BUTTON] < lo) begin
      btn_code = BTN_RELEASED;
    end else begin
      btn_v = 1'b0;
    end
  end

  // Budgeted emission in the order relay, door, button.
  always_comb begin
    emit_r    = relay_v & (relay_code != reported_relay) & (cur.space != 2'd0);
    space1    = cur.space - {1'b0, emit_r};
    emit_d    = door_v & (door_code != reported_door) & (space1 != 2'd0);
    space2    = space1 - {1'b0, emit_d};
    emit_b    = btn_v & (btn_code != reported_button) & (space2 != 2'd0);
    count_new = {1'b0, emit_r} + {1'b0, emit_d} + {1'b0, emit_b};

    m_r.source       = SRC_RELAY;
    m_r.status_code  = relay_code;
    m_r.last_of_tick = 1'b0;
    m_d.source       = SRC_DOOR;
    m_d.status_code  = {1'b0, door_code};
    m_d.last_of_tick = 1'b0;
    m_b.source       = SRC_BUTTON;
    m_b.status_code  = {1'b0, btn_code};
    m_b.last_of_tick = 1'b0;

    new_slot[0] = emit_r ? m_r : (emit_d ? m_d : m_b);
    new_slot[1] = (emit_r && emit_d) ? m_d : m_b;
    new_slot[2] = m_b;
    new_slot[0].last_of_tick = (count_new == 2'd1);
    new_slot[1].last_of_tick = (count_new == 2'd2);
    new_slot[2].last_of_tick = (count_new == 2'd3);
  end

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE:   if (head.valid) state_next = ST_PAIR01;
      ST_PAIR01: state_next = ST_PAIR23;
      ST_PAIR23: state_next = ST_PAIR56;
      ST_PAIR56: state_next = ST_FAIL;
      ST_FAIL:   state_next = ST_REPORT;
      ST_REPORT: begin
        if (buf_empty) begin
          state_next = head.valid ? ST_PAIR01 : ST_IDLE;
        end
      end
      default:   state_next = ST_IDLE;
    endcase
  end

  assign out_pop      = msg_valid & ~msg_stall;
  assign msg_valid    = ~buf_empty;
  assign source       = slot[0].source;
  assign status_code  = slot[0].status_code;
  assign last_of_tick = slot[0].last_of_tick;

  always_ff @(posedge clk) begin
    if (rst) begin
      state           <= ST_IDLE;
      gain            <= GAIN_RESET;
      high_thr        <= HIGH_RESET;
      low_thr         <= LOW_RESET;
      reported_relay  <= RELAY_NONE;
      reported_door   <= SIDE_NONE;
      reported_button <= SIDE_NONE;
      count           <= 2'd0;
      for (int i = 0; i < NUM_FILTERS; i++) begin
        level[i] <= HALF_LEVEL;
      end
    end else begin
      state <= state_next;

      if (cfg_we) begin
        case (cfg_index)
          REG_GAIN: gain     <= cfg_data;
          REG_HIGH: high_thr <= cfg_data;
          REG_LOW:  low_thr  <= cfg_data;
          default: begin
          end
        endcase
      end

      case (state)
        ST_PAIR23: begin
          level[FLT_ERROR] <= upd_a;
          level[FLT_OPEN]  <= upd_b;
        end
        ST_PAIR56: begin
          level[FLT_CLOSED]  <= upd_a;
          level[FLT_UNKNOWN] <= upd_b;
        end
        ST_FAIL: begin
          level[FLT_DOOR]   <= upd_a;
          level[FLT_BUTTON] <= upd_b;
        end
        ST_REPORT: begin
          if (buf_empty) begin
            level[FLT_FAILED] <= upd_a;
          end
        end
        default: begin
        end
      endcase

      if (report_fire) begin
        if (emit_r) reported_relay  <= relay_code;
        if (emit_d) reported_door   <= door_code;
        if (emit_b) reported_button <= btn_code;
        count <= count_new;
      end else if (out_pop) begin
        count <= count - 2'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      cur <= head.data;
    end
    if (state != ST_REPORT) begin
      lv_a_q <= lv_a;
      lv_b_q <= lv_b;
      prod_a <= alpha_s * diff_a;
      prod_b <= alpha_s * diff_b;
    end
    if (report_fire) begin
      for (int i = 0; i < MSG_SLOTS; i++) begin
        slot[i] <= new_slot[i];
      end
    end else if (out_pop) begin
      slot[0] <= slot[1];
      slot[1] <= slot[2];
    end
  end

`ifndef SYNTH
  a_report_waits: assert property (@(posedge clk) disable iff (rst)
    (state == ST_REPORT && count != 2'd0) |=> (state == ST_REPORT))
    else $error("report cycle left while messages were still buffered");

  a_last_is_final: assert property (@(posedge clk) disable iff (rst)
    (count != 2'd0 && slot[0].last_of_tick) |-> (count == 2'd1))
    else $error("last-of-tick flag on a message that is not the final one");

  a_relay_code: assert property (@(posedge clk) disable iff (rst)
    (reported_relay <= RELAY_FAILED) || (reported_relay == RELAY_NONE))
    else $error("reported relay class out of range");

  a_pop_starts: assert property (@(posedge clk) disable iff (rst)
    pop |=> (state == ST_PAIR01))
    else $error("tick taken from queue without starting the filter passes");

  a_level_range: assert property (@(posedge clk) disable iff (rst)
    level[FLT_FAILED] <= ONE_LEVEL)
    else $error("failed filter level above 1.0");
`endif

endmodule
